// ===== src/rbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the repeated box detector.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // configuration field widths
  localparam int LOC_BITS      = 13;
  localparam int SIZE_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_DETECT_ENABLE  = 2'd0;
  localparam cfg_idx_t CFG_LOCATION_LIMIT = 2'd1;
  localparam cfg_idx_t CFG_SIZE_LIMIT     = 2'd2;

  // reset values
  localparam logic                 DETECT_ENABLE_RST  = 1'b1;
  localparam logic [LOC_BITS-1:0]  LOCATION_LIMIT_RST = 13'd16;
  localparam logic [SIZE_BITS-1:0] SIZE_LIMIT_RST     = 16'd51;

  // back-end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIFF,
    BK_MUL,
    BK_SUM,
    BK_DECIDE
  } back_state_t;

endpackage

// ===== src/rbd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_in_if
// Point channel: one detection point per item.
// ----------------------------------------------------------------------------
interface rbd_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;
  logic                  empty_detection;

  modport source (output valid, point_x, point_y, last_point, empty_detection,
                  input ready);
  modport sink   (input valid, point_x, point_y, last_point, empty_detection,
                  output ready);
endinterface

// ===== src/rbd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_out_if
// Result channel: one same/not-same flag per detection.
// ----------------------------------------------------------------------------
interface rbd_out_if;
  logic valid;
  logic ready;
  logic same_box;

  modport source (output valid, same_box, input ready);
  modport sink   (input valid, same_box, output ready);
endinterface

// ===== src/rbd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rbd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rbd_pkg::CFG_IDX_BITS-1:0]   index;
  logic [rbd_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/repeated_box_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeated_box_detector
// Tracks the bounding box of each detection and flags boxes that repeat the
// stored reference box in location and size.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while the two-entry job queue has room; a
// middle point yields no result. Each last point or empty detection queues
// one job. The back-end sequencer takes each box compare through the steps
// pop, centre difference, multiply, sum and decide; a job that reports 0
// directly needs only the pop step. Detections that end faster than the back
// end can finish them fill the queue and hold off new points. A result waits
// in the output register while the next job is worked on. Configuration
// writes are always taken, and must be made only while the block is idle.
module repeated_box_detector #(
  parameter int COORD_BITS     = 12,
  parameter int SIZE_FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rbd_in_if.sink     in_chan,
  rbd_out_if.source  out_chan,
  rbd_cfg_if.sink    cfg_chan
);
  import rbd_pkg::*;

  localparam int QW      = 4 * COORD_BITS + 3;
  localparam int Q_DEPTH = 2;

  logic                 detect_enable_r;
  logic [LOC_BITS-1:0]  location_limit_r;
  logic [SIZE_BITS-1:0] size_limit_r;

  logic          push, q_full, q_empty, pop;
  logic [QW-1:0] push_data, q_data;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_enable_r  <= DETECT_ENABLE_RST;
      location_limit_r <= LOCATION_LIMIT_RST;
      size_limit_r     <= SIZE_LIMIT_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        CFG_DETECT_ENABLE:  detect_enable_r  <= cfg_chan.data[0];
        CFG_LOCATION_LIMIT: location_limit_r <= cfg_chan.data[LOC_BITS-1:0];
        CFG_SIZE_LIMIT:     size_limit_r     <= cfg_chan.data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  rbd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .detect_enable (detect_enable_r),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  rbd_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  rbd_back #(
    .COORD_BITS     (COORD_BITS),
    .SIZE_FRAC_BITS (SIZE_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .pop            (pop),
    .location_limit (location_limit_r),
    .size_limit     (size_limit_r),
    .out_chan       (out_chan)
  );
endmodule

// ===== src/rbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_queue
// Small register FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module rbd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

// ===== src/rbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_front
// Accepts points, tracks the running bounding box and queues one job per
// finished or empty detection.
// ----------------------------------------------------------------------------
module rbd_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  rbd_in_if.sink                   in_chan,
  input  logic                     detect_enable,
  output logic                     push,
  output logic [4*COORD_BITS+2:0]  push_data,
  input  logic                     q_full
);
  localparam int C = COORD_BITS;

  logic [C-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [C-1:0] min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;
  logic         collecting_r, collecting_nxt;
  logic         accept;
  logic         is_zero;
  logic [C:0]   cx2, cy2;
  logic [C-1:0] w, h;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // disabled or empty items bypass the box tracker entirely
  assign is_zero = !detect_enable || in_chan.empty_detection;

  always_comb begin
    min_x_nxt      = min_x_r;
    max_x_nxt      = max_x_r;
    min_y_nxt      = min_y_r;
    max_y_nxt      = max_y_r;
    collecting_nxt = collecting_r;
    push           = 1'b0;
    if (accept) begin
      if (is_zero) begin
        push = in_chan.last_point || in_chan.empty_detection;
      end else begin
        if (!collecting_r) begin
          min_x_nxt = in_chan.point_x;
          max_x_nxt = in_chan.point_x;
          min_y_nxt = in_chan.point_y;
          max_y_nxt = in_chan.point_y;
        end else begin
          if (in_chan.point_x < min_x_r) min_x_nxt = in_chan.point_x;
          if (in_chan.point_x > max_x_r) max_x_nxt = in_chan.point_x;
          if (in_chan.point_y < min_y_r) min_y_nxt = in_chan.point_y;
          if (in_chan.point_y > max_y_r) max_y_nxt = in_chan.point_y;
        end
        collecting_nxt = !in_chan.last_point;
        push           = in_chan.last_point;
      end
    end
  end

  assign cx2       = {1'b0, min_x_nxt} + {1'b0, max_x_nxt};
  assign cy2       = {1'b0, min_y_nxt} + {1'b0, max_y_nxt};
  assign w         = max_x_nxt - min_x_nxt;
  assign h         = max_y_nxt - min_y_nxt;
  assign push_data = {is_zero, cx2, cy2, w, h};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
    end else begin
      collecting_r <= collecting_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_x_r <= min_x_nxt;
    max_x_r <= max_x_nxt;
    min_y_r <= min_y_nxt;
    max_y_r <= max_y_nxt;
  end
endmodule

// ===== src/rbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_back
// Compares each finished box with the reference box, keeps the reference
// and drives the result register.
// ----------------------------------------------------------------------------
module rbd_back #(
  parameter int COORD_BITS     = 12,
  parameter int SIZE_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  logic [4*COORD_BITS+2:0]             q_data,
  output logic                                pop,
  input  logic [rbd_pkg::LOC_BITS-1:0]        location_limit,
  input  logic [rbd_pkg::SIZE_BITS-1:0]       size_limit,
  rbd_out_if.source                           out_chan
);
  import rbd_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int F      = SIZE_FRAC_BITS;
  localparam int SQ_W   = 2 * C + 2;
  localparam int DIST_W = 2 * C + 3;
  localparam int LL_W   = 2 * LOC_BITS;
  localparam int LIM_W  = 2 * LOC_BITS + 2;
  localparam int DL_W   = (DIST_W > LIM_W) ? DIST_W : LIM_W;
  localparam int AREA_W = 2 * C;
  localparam int SH_W   = 2 * C + F;
  localparam int PROD_W = SIZE_BITS + 2 * C;
  localparam int SZ_W   = (SH_W > PROD_W) ? SH_W : PROD_W;

  back_state_t st_r, st_nxt;

  logic             job_zero;
  logic [C:0]       job_cx2, job_cy2;
  logic [C-1:0]     job_w, job_h;

  logic [C:0]       j_cx2_r, j_cy2_r;
  logic [C-1:0]     j_w_r, j_h_r;
  logic [C:0]       adx_r, ady_r;
  logic [SQ_W-1:0]  dxsq_r, dysq_r;
  logic [LL_W-1:0]  llsq_r;
  logic [AREA_W-1:0] area_r, rarea_r, adiff_r;
  logic [DIST_W-1:0] dist_r;
  logic [LIM_W-1:0] lim_r;
  logic [PROD_W-1:0] prod_r;
  logic             rzero_r;

  logic             have_ref_r;
  logic [C:0]       ref_cx2_r, ref_cy2_r;
  logic [C-1:0]     ref_w_r, ref_h_r;

  logic             out_valid_r, out_valid_nxt;
  logic             same_r, same_nxt;

  logic             load, upd, slot_free;
  logic             loc_ok, size_ok, same_w;
  logic [SH_W-1:0]  shifted;

  assign {job_zero, job_cx2, job_cy2, job_w, job_h} = q_data;

  assign slot_free         = !out_valid_r || out_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.same_box = same_r;

  assign shifted = {adiff_r, {F{1'b0}}};
  assign loc_ok  = DL_W'(dist_r) < DL_W'(lim_r);
  // an empty reference box only passes on a nonzero threshold
  assign size_ok = rzero_r ? (size_limit != '0) : (SZ_W'(shifted) < SZ_W'(prod_r));
  assign same_w  = have_ref_r && loc_ok && size_ok;

  always_comb begin
    st_nxt        = st_r;
    pop           = 1'b0;
    load          = 1'b0;
    upd           = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    same_nxt      = same_r;
    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (job_zero) begin
            if (slot_free) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              same_nxt      = 1'b0;
            end
          end else begin
            pop    = 1'b1;
            load   = 1'b1;
            st_nxt = BK_DIFF;
          end
        end
      end
      BK_DIFF:   st_nxt = BK_MUL;
      BK_MUL:    st_nxt = BK_SUM;
      BK_SUM:    st_nxt = BK_DECIDE;
      BK_DECIDE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          same_nxt      = same_w;
          upd           = !same_w;
          st_nxt        = BK_IDLE;
        end
      end
      default:   st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
      same_r      <= 1'b0;
      have_ref_r  <= 1'b0;
      ref_cx2_r   <= '0;
      ref_cy2_r   <= '0;
      ref_w_r     <= '0;
      ref_h_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      same_r      <= same_nxt;
      if (upd) begin
        have_ref_r <= 1'b1;
        ref_cx2_r  <= j_cx2_r;
        ref_cy2_r  <= j_cy2_r;
        ref_w_r    <= j_w_r;
        ref_h_r    <= j_h_r;
      end
    end
  end

  // datapath, one step per state
  always_ff @(posedge clk) begin
    if (load) begin
      j_cx2_r <= job_cx2;
      j_cy2_r <= job_cy2;
      j_w_r   <= job_w;
      j_h_r   <= job_h;
    end
    if (st_r == BK_DIFF) begin
      adx_r <= (j_cx2_r >= ref_cx2_r) ? j_cx2_r - ref_cx2_r : ref_cx2_r - j_cx2_r;
      ady_r <= (j_cy2_r >= ref_cy2_r) ? j_cy2_r - ref_cy2_r : ref_cy2_r - j_cy2_r;
    end
    if (st_r == BK_MUL) begin
      dxsq_r  <= SQ_W'(adx_r) * SQ_W'(adx_r);
      dysq_r  <= SQ_W'(ady_r) * SQ_W'(ady_r);
      llsq_r  <= LL_W'(location_limit) * LL_W'(location_limit);
      area_r  <= AREA_W'(j_w_r) * AREA_W'(j_h_r);
      rarea_r <= AREA_W'(ref_w_r) * AREA_W'(ref_h_r);
    end
    if (st_r == BK_SUM) begin
      dist_r  <= DIST_W'(dxsq_r) + DIST_W'(dysq_r);
      lim_r   <= {llsq_r, 2'b00};
      adiff_r <= (area_r >= rarea_r) ? area_r - rarea_r : rarea_r - area_r;
      prod_r  <= PROD_W'(size_limit) * PROD_W'(rarea_r);
      rzero_r <= (rarea_r == '0);
    end
  end
endmodule

// ===== src/rbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the repeated box detector, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_same_box
);
  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_same_box))
    else $error("result changed while stalled");

  // reset leaves no pending result
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // reset empties the job queue, so points are taken at once
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");
endmodule

bind repeated_box_detector rbd_checker u_rbd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_same_box (out_chan.same_box)
);
